### design/ecc_pkg.sv
// types and constants shared by the elevator car controller
`timescale 1ns / 1ps

package ecc_pkg;

    localparam int LEVEL_W = 10;

    typedef logic [LEVEL_W-1:0] t_level;

    typedef enum logic [2:0] {
        DOOR_CLOSED  = 3'd0,
        DOOR_OPENING = 3'd1,
        DOOR_OPEN    = 3'd2,
        DOOR_CLOSING = 3'd3,
        DOOR_BETWEEN = 3'd4
    } t_door;

    typedef enum logic [1:0] {
        NOTICE_NONE      = 2'd0,
        NOTICE_EMERGENCY = 2'd1,
        NOTICE_SERVICE   = 2'd2
    } t_notice;

    typedef enum logic [0:0] {
        CFG_LOWEST_FLOOR  = 1'b0,
        CFG_HIGHEST_FLOOR = 1'b1
    } t_cfg_reg;

    localparam logic [1:0] WATCHDOG_LIMIT = 2'd3;
    localparam logic [1:0] WATCHDOG_ONE   = 2'd1;

    typedef struct packed {
        logic   open_press;
        logic   close_press;
        logic   dest_valid;
        t_level dest_floor;
        logic   dest_from_link;
        logic   service_mode;
        logic   emergency_set;
        logic   heartbeat;
    } t_in_item;

    typedef struct packed {
        t_door   door_status;
        t_level  current_level;
        t_level  target_level;
        logic    in_emergency;
        logic    link_up;
        t_notice notice;
    } t_result;

    typedef struct packed {
        t_cfg_reg index;
        t_level   value;
    } t_cfg_write;

    // input register contents handed to the core
    typedef struct packed {
        logic     valid;
        t_in_item item;
    } t_stage;

endpackage

### design/ecc_stream_if.sv
// valid/ready channel carrying one payload per transfer
`timescale 1ns / 1ps

interface ecc_stream_if #(
    parameter type T = logic
) ();
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

### design/ecc_in_stage.sv
// input register stage of the elevator car controller
`timescale 1ns / 1ps

module ecc_in_stage (
    input  logic           i_clk,
    input  logic           i_rst_n,
    ecc_stream_if.sink     i_in,
    input  logic           i_advance,
    output ecc_pkg::t_stage o_stage
);
    import ecc_pkg::*;

    logic     r_valid;
    t_in_item r_item;

    // takes a new item when empty or when the held one moves on
    assign i_in.ready = !r_valid || i_advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_item <= i_in.data;
        end
    end

    assign o_stage.valid = r_valid;
    assign o_stage.item  = r_item;

endmodule

### design/ecc_core.sv
// car state, configuration registers, tick update and result register
`timescale 1ns / 1ps

module ecc_core #(
    parameter int FLOOR_LEVELS = 1024
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  ecc_pkg::t_stage i_stage,
    ecc_stream_if.sink      i_cfg,
    ecc_stream_if.source    o_out,
    output logic            o_advance
);
    import ecc_pkg::*;

    localparam t_level MaxLevel = LEVEL_W'(FLOOR_LEVELS - 1);

    // configuration
    t_level r_lowest;
    t_level r_highest;
    t_level cfg_clamped;

    // car state
    t_door  r_door,  n_door;
    t_level r_car,   n_car;
    t_level r_goal,  n_goal;
    logic   r_emg,   n_emg;
    logic   r_link,  n_link;
    logic [1:0] r_wd, n_wd;
    logic   r_ticked;
    t_notice n_notice;

    // result register
    logic    r_out_valid;
    t_result r_res, n_res;

    t_in_item   it;
    logic       dest_ok;
    logic       door_done;
    logic       normal;
    logic [2:0] wd_inc;

    assign it          = i_stage.item;
    assign i_cfg.ready = 1'b1;
    assign cfg_clamped = (i_cfg.data.value > MaxLevel) ? MaxLevel : i_cfg.data.value;
    assign o_advance   = i_stage.valid && (!r_out_valid || o_out.ready);

    // next state for one tick
    always_comb begin
        n_emg    = r_emg | it.emergency_set;
        n_wd     = it.heartbeat ? WATCHDOG_ONE : r_wd;
        n_link   = r_link;
        n_goal   = r_goal;
        n_car    = r_car;
        n_door   = r_door;
        n_notice = NOTICE_NONE;
        dest_ok  = it.dest_floor <= MaxLevel;
        wd_inc   = {1'b0, n_wd} + 3'd1;

        if (!r_link) begin
            if (n_wd == WATCHDOG_ONE && !it.service_mode && !n_emg) begin
                n_link = 1'b1;
            end
        end else if (wd_inc >= {1'b0, WATCHDOG_LIMIT}) begin
            n_wd     = WATCHDOG_LIMIT;
            n_emg    = 1'b1;
            n_notice = NOTICE_EMERGENCY;
            n_link   = 1'b0;
        end else begin
            n_wd = wd_inc[1:0];
            if (it.dest_valid && it.dest_from_link && dest_ok &&
                it.dest_floor >= r_lowest && it.dest_floor <= r_highest) begin
                n_goal = it.dest_floor;
            end
            if (it.service_mode) begin
                n_notice = NOTICE_SERVICE;
                n_link   = 1'b0;
            end else if (n_emg) begin
                n_notice = NOTICE_EMERGENCY;
                n_link   = 1'b0;
            end
        end

        // local panel request
        if (it.dest_valid && !it.dest_from_link && dest_ok) begin
            n_goal = it.dest_floor;
        end

        door_done = 1'b0;
        if (it.open_press && (r_door == DOOR_CLOSED || r_door == DOOR_CLOSING)) begin
            n_door    = DOOR_OPENING;
            door_done = 1'b1;
        end
        if (it.close_press && r_door == DOOR_OPEN) begin
            n_door    = DOOR_CLOSING;
            door_done = 1'b1;
        end

        normal = !n_emg && !it.service_mode;
        if (!door_done) begin
            unique case (r_door)
                DOOR_OPENING: n_door = DOOR_OPEN;
                DOOR_OPEN: begin
                    if (normal) begin
                        n_door = DOOR_CLOSING;
                    end
                end
                DOOR_CLOSING: n_door = DOOR_CLOSED;
                DOOR_BETWEEN: begin
                    if (!n_emg) begin
                        if (it.service_mode) begin
                            n_car  = n_goal;
                            n_door = DOOR_CLOSED;
                        end else begin
                            if (r_car < n_goal) begin
                                n_car = r_car + t_level'(1);
                            end else if (r_car > n_goal) begin
                                n_car = r_car - t_level'(1);
                            end
                            n_door = (n_car == n_goal) ? DOOR_OPENING : DOOR_CLOSED;
                        end
                    end
                end
                default: begin
                    n_door = (!n_emg && r_car != n_goal) ? DOOR_BETWEEN : DOOR_CLOSED;
                end
            endcase
        end
    end

    // result of the tick
    always_comb begin
        n_res.door_status   = n_door;
        n_res.current_level = n_car;
        n_res.target_level  = n_goal;
        n_res.in_emergency  = n_emg;
        n_res.link_up       = n_link;
        n_res.notice        = n_notice;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lowest  <= '0;
            r_highest <= MaxLevel;
            r_door    <= DOOR_CLOSED;
            r_car     <= '0;
            r_goal    <= '0;
            r_emg     <= 1'b0;
            r_link    <= 1'b0;
            r_wd      <= '0;
            r_ticked  <= 1'b0;
        end else begin
            if (i_cfg.valid) begin
                unique case (i_cfg.data.index)
                    CFG_LOWEST_FLOOR: begin
                        r_lowest <= cfg_clamped;
                        // start floor follows until the first tick
                        if (!r_ticked) begin
                            r_car  <= cfg_clamped;
                            r_goal <= cfg_clamped;
                        end
                    end
                    CFG_HIGHEST_FLOOR: r_highest <= cfg_clamped;
                    default: ;
                endcase
            end
            if (o_advance) begin
                r_door   <= n_door;
                r_car    <= n_car;
                r_goal   <= n_goal;
                r_emg    <= n_emg;
                r_link   <= n_link;
                r_wd     <= n_wd;
                r_ticked <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_advance) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_advance) begin
            r_res <= n_res;
        end
    end

    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_res;

    a_emg_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_emg |=> r_emg)
        else $error("emergency latch cleared outside reset");

    a_link_no_emg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_link |-> !r_emg)
        else $error("link up while in emergency");

    a_link_wd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_link |-> (r_wd == 2'd1 || r_wd == 2'd2))
        else $error("link up with watchdog count out of range");

    a_notice_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_res.notice != NOTICE_NONE) |-> !r_res.link_up)
        else $error("notice sent while link stays up");

    a_emg_notice: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_res.notice == NOTICE_EMERGENCY) |-> r_res.in_emergency)
        else $error("emergency notice without emergency latch");

endmodule

### design/elevator_car_controller_top.sv
// Elevator car controller: one input transfer is one control tick and gives
// exactly one result transfer with the state after that tick. Items are taken
// at one per clock while the output is not stalled; an item passes the input
// register and then the tick update, which loads the car state and the result
// register together, so the car state feeds the next tick directly. The result
// register lets the next item be taken while a result waits. Configuration
// writes (lowest_floor, highest_floor) are always ready; values above the top
// level are saturated, and a lowest_floor write before the first tick also
// sets the start level.
`timescale 1ns / 1ps

module elevator_car_controller_top #(
    parameter int FLOOR_LEVELS = 1024
) (
    input logic          i_clk,
    input logic          i_rst_n,
    ecc_stream_if.sink   i_in,
    ecc_stream_if.sink   i_cfg,
    ecc_stream_if.source o_out
);
    import ecc_pkg::*;

    t_stage stage;
    logic   advance;

    ecc_in_stage u_in_stage (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in      (i_in),
        .i_advance (advance),
        .o_stage   (stage)
    );

    ecc_core #(
        .FLOOR_LEVELS (FLOOR_LEVELS)
    ) u_core (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_stage   (stage),
        .i_cfg     (i_cfg),
        .o_out     (o_out),
        .o_advance (advance)
    );

endmodule
